@@ design/psm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants for the pair-sum membership table.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int DATA_W           = 32;
  localparam int CNT_OUT_W        = 7;
  localparam int DEFAULT_CAPACITY = 64;
  // width of one group in the hit reduction tree
  localparam int GROUP_W          = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_WAIT,
    ST_ADD_DECIDE,
    ST_FIND,
    ST_DONE
  } state_t;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_FIND = 1'b1
  } cmd_t;

  // sequencer -> store requests
  typedef struct packed {
    logic              cmp_en;     // run the parallel compare against key
    logic [DATA_W-1:0] key;        // compare key, also write data on add
    logic              key_ok;     // key is a real 32-bit value
    logic              need_self;  // key equals the swept value: need count of 2
    logic              set_dup;    // mark hit entry as seen twice
    logic              add_new;    // append key as a new entry
  } store_req_t;

endpackage
`default_nettype wire

@@ design/psm_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psm_store
// Value storage: a read memory for the sweep, a row of match cells compared
// in parallel against one key, per-entry duplicate flags and the fill count.
// ----------------------------------------------------------------------------
module psm_store #(
  parameter int CAPACITY = psm_pkg::DEFAULT_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int UW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire psm_pkg::store_req_t        req,
  input  wire logic [AW-1:0]              rd_addr,
  output logic [psm_pkg::DATA_W-1:0]      rd_data,
  output logic                            hit_any,
  output logic [UW-1:0]                   used
);

  localparam int NGRP = (CAPACITY + psm_pkg::GROUP_W - 1) / psm_pkg::GROUP_W;

  logic [psm_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [psm_pkg::DATA_W-1:0] cam [CAPACITY];
  logic [CAPACITY-1:0]        dup;
  logic [CAPACITY-1:0]        hit_q;
  logic [NGRP-1:0]            grp_c;
  logic [NGRP-1:0]            grp_q;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (req.add_new) begin
      mem[used[AW-1:0]] <= req.key;
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    localparam logic [UW-1:0] IDX = UW'(j);

    always_ff @(posedge clk) begin
      if (req.add_new && used == IDX) begin
        cam[j] <= req.key;
        dup[j] <= 1'b0;
      end else if (req.set_dup && hit_q[j]) begin
        dup[j] <= 1'b1;
      end
      if (req.cmp_en) begin
        hit_q[j] <= (IDX < used) && req.key_ok && (cam[j] == req.key) &&
                    (dup[j] || !req.need_self);
      end
    end
  end

  // two-level reduction of the hit vector
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int LO = g * psm_pkg::GROUP_W;
    localparam int HI = (LO + psm_pkg::GROUP_W > CAPACITY) ?
                        CAPACITY - 1 : LO + psm_pkg::GROUP_W - 1;
    assign grp_c[g] = |hit_q[HI:LO];
  end

  always_ff @(posedge clk) begin
    grp_q <= grp_c;
  end

  assign hit_any = |grp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (req.add_new) begin
      used <= used + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(CAPACITY))
    else $error("fill count above capacity");

  a_dup_xor_new: assert property (@(posedge clk) disable iff (rst)
    !(req.set_dup && req.add_new))
    else $error("add both appends and marks a duplicate");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    req.add_new |=> used == $past(used) + 1'b1)
    else $error("fill count did not advance on append");
`endif

endmodule
`default_nettype wire

@@ design/psm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psm_ctrl
// Sequencer: input capture, add decision, pipelined find sweep through the
// shared subtractor and match row, and the output register.
// ----------------------------------------------------------------------------
module psm_ctrl #(
  parameter int CAPACITY = psm_pkg::DEFAULT_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int UW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              command,
  input  wire logic signed [psm_pkg::DATA_W-1:0] operand,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   pair_found,
  output logic                                   table_full,
  output logic [psm_pkg::CNT_OUT_W-1:0]          distinct_count,
  output psm_pkg::store_req_t                    req,
  output logic [AW-1:0]                          rd_addr,
  input  wire logic [psm_pkg::DATA_W-1:0]        rd_data,
  input  wire logic                              hit_any,
  input  wire logic [UW-1:0]                     used
);

  localparam int              DW    = psm_pkg::DATA_W;
  localparam int              OW    = psm_pkg::CNT_OUT_W;
  localparam logic [UW-1:0]   CAP_U = UW'(CAPACITY);

  psm_pkg::state_t state, state_next;

  logic [DW-1:0] target;
  logic [UW-1:0] idx;
  logic          rd_v, gap_v, cmp_v, res_v;
  logic [DW:0]   gap_q, gap_c;
  logic          ok_q, self_q;
  logic          found, full;
  logic          accept, rd_issue, load_out, has_room;

  assign accept   = in_valid && !in_stall;
  assign rd_issue = (state == psm_pkg::ST_FIND) && (idx < used);
  assign rd_addr  = idx[AW-1:0];
  assign has_room = used < CAP_U;
  // 33-bit difference, cannot overflow
  assign gap_c    = {target[DW-1], target} - {rd_data[DW-1], rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    load_out      = 1'b0;
    req.cmp_en    = gap_v;
    req.key       = gap_q[DW-1:0];
    req.key_ok    = ok_q;
    req.need_self = self_q;
    req.set_dup   = 1'b0;
    req.add_new   = 1'b0;
    case (state)
      psm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (command == psm_pkg::CMD_FIND) ? psm_pkg::ST_FIND
                                                      : psm_pkg::ST_ADD_CMP;
        end
      end
      psm_pkg::ST_ADD_CMP: begin
        req.cmp_en    = 1'b1;
        req.key       = target;
        req.key_ok    = 1'b1;
        req.need_self = 1'b0;
        state_next    = psm_pkg::ST_ADD_WAIT;
      end
      psm_pkg::ST_ADD_WAIT: begin
        req.key    = target;
        state_next = psm_pkg::ST_ADD_DECIDE;
      end
      psm_pkg::ST_ADD_DECIDE: begin
        req.key     = target;
        req.set_dup = hit_any;
        req.add_new = !hit_any && has_room;
        state_next  = psm_pkg::ST_DONE;
      end
      psm_pkg::ST_FIND: begin
        if (!rd_issue && !rd_v && !gap_v && !cmp_v && !res_v) begin
          state_next = psm_pkg::ST_DONE;
        end
      end
      psm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = psm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psm_pkg::ST_IDLE;
      end
    endcase
  end

  // sweep pipeline: read, subtract, compare, reduce
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      gap_v <= 1'b0;
      cmp_v <= 1'b0;
      res_v <= 1'b0;
    end else begin
      rd_v  <= rd_issue;
      gap_v <= rd_v;
      cmp_v <= gap_v;
      res_v <= cmp_v;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target <= operand;
      idx    <= '0;
      found  <= 1'b0;
      full   <= 1'b0;
    end else begin
      if (rd_issue) begin
        idx <= idx + 1'b1;
      end
      if (res_v && hit_any) begin
        found <= 1'b1;
      end
      if (state == psm_pkg::ST_ADD_DECIDE && !hit_any && !has_room) begin
        full <= 1'b1;
      end
    end
    if (rd_v) begin
      gap_q  <= gap_c;
      ok_q   <= gap_c[DW] == gap_c[DW-1];
      self_q <= gap_c[DW-1:0] == rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pair_found     <= found;
      table_full     <= full;
      distinct_count <= OW'(used);
    end
  end

`ifndef SYNTHESIS
  a_res_in_find: assert property (@(posedge clk) disable iff (rst)
    res_v |-> state == psm_pkg::ST_FIND)
    else $error("sweep result outside find");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == psm_pkg::ST_DONE && (!out_valid || !out_stall)) |=> out_valid)
    else $error("finished transaction not presented");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pair_found && table_full))
    else $error("find and full flags both set");
`endif

endmodule
`default_nettype wire

@@ design/pair_sum_membership_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pair_sum_membership_table
// Table of distinct signed values with saturating counts; answers pair sums.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries command and operand. Command add
//   records operand; command find asks whether two stored occurrences sum to
//   operand. Each transaction gives exactly one result on the output channel
//   (out_valid/out_stall): pair_found, table_full, distinct_count.
//   An add runs the match row compare, the two-level hit reduction and the
//   update. A find sweeps the N stored values: one entry is read per cycle and
//   pushed through the shared subtractor and the parallel match row, four
//   stages deep.
//   in_stall is high from accept until the result is in the output register,
//   so one transaction is in flight at a time.
//   With no output stall the next transaction can be taken in the cycle after
//   the result is loaded.
//   The output register frees the sequencer: while a result waits under
//   out_stall the next transaction can be taken and worked; its result then
//   waits in the done state until the register is free.
//   Reset (rst, synchronous) empties the table and drops any pending result.
// ----------------------------------------------------------------------------
module pair_sum_membership_table #(
  parameter int CAPACITY = psm_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              command,
  input  wire logic signed [psm_pkg::DATA_W-1:0] operand,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   pair_found,
  output logic                                   table_full,
  output logic [psm_pkg::CNT_OUT_W-1:0]          distinct_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int UW = $clog2(CAPACITY + 1);

  psm_pkg::store_req_t         req;
  logic [AW-1:0]               rd_addr;
  logic [psm_pkg::DATA_W-1:0]  rd_data;
  logic                        hit_any;
  logic [UW-1:0]               used;

  psm_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .UW       (UW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .operand        (operand),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pair_found     (pair_found),
    .table_full     (table_full),
    .distinct_count (distinct_count),
    .req            (req),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .hit_any        (hit_any),
    .used           (used)
  );

  psm_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .UW       (UW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .hit_any (hit_any),
    .used    (used)
  );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the pair-sum membership table against a cycle-free predictor: adds
// and finds are sent with random gaps and output stalls, every result is
// compared with the predicted one, and the table is driven to full capacity.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W      = psm_pkg::DATA_W;
  localparam int CNT_OUT_W   = psm_pkg::CNT_OUT_W;
  localparam int TABLE_DEPTH = psm_pkg::DEFAULT_CAPACITY;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam longint LOW_LIMIT  = -64'sd2147483648;
  localparam longint HIGH_LIMIT = 64'sd2147483647;

  typedef struct packed {
    logic                 pair_found;
    logic                 table_full;
    logic [CNT_OUT_W-1:0] distinct_count;
  } table_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     command = psm_pkg::CMD_ADD;
  logic signed [DATA_W-1:0] operand = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     pair_found;
  logic                     table_full;
  logic [CNT_OUT_W-1:0]     distinct_count;

  pair_sum_membership_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .operand       (operand),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pair_found    (pair_found),
    .table_full    (table_full),
    .distinct_count(distinct_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted table contents
  logic signed [DATA_W-1:0] table_val [TABLE_DEPTH];
  logic [1:0]               table_cnt [TABLE_DEPTH];
  int                       table_used = 0;

  table_result_t pending_results[$];
  int  mismatches = 0;
  int  n_adds = 0, n_finds = 0, n_hits = 0, n_dropped = 0;
  bit  no_idle = 1'b0;
  int  sink_left = 0;

  function automatic int table_index_of(logic signed [DATA_W-1:0] v);
    for (int i = 0; i < table_used; i++)
      if (table_val[i] == v) return i;
    return -1;
  endfunction

  function automatic table_result_t apply_to_table(psm_pkg::cmd_t cmd,
                                                   logic signed [DATA_W-1:0] op);
    table_result_t res;
    int            idx;
    longint        target, v, gap;
    res = '0;
    if (cmd == psm_pkg::CMD_ADD) begin
      idx = table_index_of(op);
      if (idx >= 0) begin
        if (table_cnt[idx] < 2) table_cnt[idx] = table_cnt[idx] + 2'd1;
      end else if (table_used < TABLE_DEPTH) begin
        table_val[table_used] = op;
        table_cnt[table_used] = 2'd1;
        table_used++;
      end else begin
        res.table_full = 1'b1;
      end
    end else begin
      target = op;
      for (int i = 0; i < table_used && !res.pair_found; i++) begin
        v   = table_val[i];
        gap = target - v;
        // a difference outside 32 bits cannot be stored
        if (gap < LOW_LIMIT || gap > HIGH_LIMIT) continue;
        if (gap == v) begin
          if (table_cnt[i] >= 2) res.pair_found = 1'b1;
        end else if (table_index_of(gap[DATA_W-1:0]) >= 0) begin
          res.pair_found = 1'b1;
        end
      end
    end
    res.distinct_count = CNT_OUT_W'(table_used);
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 100) - 50;
      2: begin
        case ($urandom_range(0, 5))
          0: return MIN_VAL;
          1: return MAX_VAL;
          2: return MIN_VAL + 1;
          3: return MAX_VAL - 1;
          4: return 0;
          default: return -1;
        endcase
      end
      default: return $urandom ^ 32'h8000_0000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_target();
    logic signed [DATA_W-1:0] a, b;
    if (table_used == 0) return pick_value();
    a = table_val[$urandom_range(0, table_used - 1)];
    b = table_val[$urandom_range(0, table_used - 1)];
    case ($urandom_range(0, 7))
      0, 1, 2: return a + b;
      3:       return a + a;
      4:       return a + b + 1;
      5:       return a + b - 1;
      6:       return pick_value();
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(psm_pkg::cmd_t cmd, logic signed [DATA_W-1:0] op);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    command  <= cmd;
    operand  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_to_table(cmd, op));
    if (cmd == psm_pkg::CMD_ADD) n_adds++;
    else n_finds++;
  endtask

  // drop valid so the last transaction is not taken twice while waiting
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, table_result_t want, table_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch (%s): expected found=%0b full=%0b count=%0d,",
               $realtime, what, want.pair_found, want.table_full, want.distinct_count);
      $display("    got found=%0b full=%0b count=%0d",
               got.pair_found, got.table_full, got.distinct_count);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    table_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{pair_found, table_full, distinct_count};
      if (got.pair_found) n_hits++;
      if (got.table_full) n_dropped++;
      if (pending_results.size() == 0) begin
        note_mismatch("no transaction pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.pair_found !== want.pair_found || got.table_full !== want.table_full ||
            got.distinct_count !== want.distinct_count)
          note_mismatch("field", want, got);
      end
    end
  end

  // output back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_stall <= 1'b0;
      sink_left = 0;
    end else if (sink_left > 0) begin
      out_stall <= 1'b1;
      sink_left--;
    end else if ($urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      sink_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_directed();
    send_item(psm_pkg::CMD_FIND, 0);          // empty table
    send_item(psm_pkg::CMD_FIND, MIN_VAL);
    send_item(psm_pkg::CMD_ADD, MIN_VAL);
    send_item(psm_pkg::CMD_FIND, MIN_VAL);
    send_item(psm_pkg::CMD_FIND, 0);          // difference above 32-bit range
    send_item(psm_pkg::CMD_ADD, MIN_VAL);
    send_item(psm_pkg::CMD_FIND, MIN_VAL);    // 2*MIN is not representable
    send_item(psm_pkg::CMD_ADD, MAX_VAL);
    send_item(psm_pkg::CMD_FIND, -1);
    send_item(psm_pkg::CMD_FIND, -2);
    send_item(psm_pkg::CMD_ADD, 0);
    send_item(psm_pkg::CMD_FIND, 0);          // single occurrence only
    send_item(psm_pkg::CMD_ADD, 0);
    send_item(psm_pkg::CMD_FIND, 0);
    send_item(psm_pkg::CMD_ADD, 0);           // count saturates
    send_item(psm_pkg::CMD_FIND, MAX_VAL);
    send_item(psm_pkg::CMD_ADD, -1);
    send_item(psm_pkg::CMD_FIND, MAX_VAL - 1);
    send_item(psm_pkg::CMD_FIND, 32'sh7FFF_FFFE + 32'sh0000_0001);
    send_item(psm_pkg::CMD_ADD, 32'shAAAA_AAAA);
    send_item(psm_pkg::CMD_ADD, 32'sh5555_5555);
    send_item(psm_pkg::CMD_FIND, -1);
    send_item(psm_pkg::CMD_FIND, 32'sh5555_5554);
  endtask

  // new_pct: share of adds that bring a fresh value
  task automatic test_random_mix(int n_items, int new_pct);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 50)
        send_item(psm_pkg::CMD_FIND, pick_target());
      else if (table_used > 0 && $urandom_range(0, 99) >= new_pct)
        send_item(psm_pkg::CMD_ADD, table_val[$urandom_range(0, table_used - 1)]);
      else
        send_item(psm_pkg::CMD_ADD, pick_value());
    end
  endtask

  task automatic test_drain_pause();
    send_item(psm_pkg::CMD_ADD, pick_value());
    send_item(psm_pkg::CMD_FIND, pick_target());
    wait_all_results();
    send_item(psm_pkg::CMD_FIND, pick_target());
    send_item(psm_pkg::CMD_ADD, pick_value());
  endtask

  task automatic test_full_table();
    logic signed [DATA_W-1:0] v;
    while (table_used < TABLE_DEPTH) begin
      do v = $urandom; while (table_index_of(v) >= 0);
      send_item(psm_pkg::CMD_ADD, v);
    end
    for (int k = 0; k < 4; k++) begin
      do v = pick_value(); while (table_index_of(v) >= 0);
      send_item(psm_pkg::CMD_ADD, v);         // dropped
      send_item(psm_pkg::CMD_ADD, table_val[$urandom_range(0, TABLE_DEPTH - 1)]);
      send_item(psm_pkg::CMD_FIND, pick_target());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(600, 12);
    test_drain_pause();
    test_full_table();
    test_random_mix(950, 30);
    no_idle <= 1'b1;
    test_random_mix(300, 30);
    wait_all_results();
    repeat (TABLE_DEPTH + 20) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("Run covered %0d adds and %0d finds: %0d pairs found,",
             n_adds, n_finds, n_hits);
    $display("%0d adds dropped on a full table, %0d distinct values held, %0d mismatches.",
             n_dropped, table_used, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Run timed out with %0d results pending.", pending_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
